FILE: hdl/spqv_pkg.sv
package spqv_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_BITS  = 12;

  // field widths fixed by the interface
  localparam int FW         = 32;
  localparam int ANGLE_IN_W = 12;

  localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  // quarter-wave sine table: entries 0..QTR, magnitude up to 1.0 in Q16
  localparam int QTR    = 1 << (ANGLE_BITS - 2);
  localparam int ROM_AW = ANGLE_BITS - 1;
  localparam int SIN_W  = 17;
  localparam int TRIG_W = SIN_W + 1;

  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;
  localparam int FRAC_W   = 16;

  // datapath widths
  localparam int OFF_W    = FW + 1;
  localparam int PROD_W   = OFF_W + FW;
  localparam int SAT_IN_W = PROD_W - FRAC_W;
  localparam int ROT_W    = TRIG_W + FW;
  localparam int RSUM_W   = ROT_W + 1;
  localparam int RND_W    = RSUM_W - FRAC_W;
  localparam int VSUM_W   = RND_W + 1;

  localparam logic [63:0] HALF_PI_Q46 = 64'h1921FB54442D1847 >> 14;

  typedef logic signed [FW-1:0]     coord_t;
  typedef logic [ANGLE_IN_W-1:0]    angle_in_t;
  typedef logic [ANGLE_BITS-1:0]    angle_t;
  typedef logic [ROM_AW-1:0]        rom_addr_t;
  typedef logic [SIN_W-1:0]         sin_mag_t;
  typedef sin_mag_t                 sin_tab_t [0:QTR];
  typedef logic [1:0]               corner_t;
  typedef logic [1:0]               mirror_t;

  localparam corner_t CORNER_LAST = 2'd3;

  // base corner flags, bit k for corner k
  localparam logic [3:0] KX_FLAGS = 4'b0011;
  localparam logic [3:0] KY_FLAGS = 4'b1001;

  localparam int MIR_H = 0;
  localparam int MIR_V = 1;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI =
    signed'({{(SAT_IN_W - SAT_BITS + 1){1'b0}}, {(SAT_BITS - 1){1'b1}}});
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    coord_t  dest_x;
    coord_t  dest_y;
    coord_t  dest_w;
    coord_t  dest_h;
    coord_t  pivot_x;
    coord_t  pivot_y;
    coord_t  src_u;
    coord_t  src_v;
    coord_t  src_w;
    coord_t  src_h;
    mirror_t mirror;
    logic    sin_neg;
    logic    cos_neg;
  } item_t;

  typedef struct packed {
    item_t    item;
    sin_mag_t sin_mag;
    sin_mag_t cos_mag;
  } sprite_t;

  function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v);
    if (v > SAT_HI) begin
      return coord_t'(SAT_HI[FW-1:0]);
    end else if (v < SAT_LO) begin
      return coord_t'(SAT_LO[FW-1:0]);
    end
    return coord_t'(v[FW-1:0]);
  endfunction

  // table address for one angle, using quarter-wave symmetry
  function automatic rom_addr_t quarter_addr(input angle_t a);
    rom_addr_t r;
    r = rom_addr_t'(a[ANGLE_BITS-3:0]);
    if (a[ANGLE_BITS-2]) begin
      return rom_addr_t'(QTR) - r;
    end
    return r;
  endfunction

  // Taylor series to x^17, Q30, truncated at every step
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k <= QTR; k++) begin
      if (k == 0) begin
        tab[k] = '0;
      end else if (k == QTR) begin
        tab[k] = SIN_W'(ONE_Q16);
      end else begin
        x = (64'(k) * HALF_PI_Q46 + (64'd1 << (ANGLE_BITS + 13))) >> (ANGLE_BITS + 14);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 8; n++) begin
          term = (term * x2) >> 30;
          case (n)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            6: term = term / 64'd156;
            7: term = term / 64'd210;
            default: term = term / 64'd272;
          endcase
          if (n % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        sum = (sum + 8192) >>> 14;
        if (sum > ONE_Q16) begin
          sum = ONE_Q16;
        end
        tab[k] = SIN_W'(sum);
      end
    end
    return tab;
  endfunction

endpackage

FILE: hdl/spqv_sine_rom.sv
module spqv_sine_rom (
  input  logic                 clk,
  input  logic                 en,
  input  spqv_pkg::rom_addr_t  addr_a,
  input  spqv_pkg::rom_addr_t  addr_b,
  output spqv_pkg::sin_mag_t   data_a,
  output spqv_pkg::sin_mag_t   data_b
);

  localparam spqv_pkg::sin_tab_t SIN_TAB = spqv_pkg::build_sin_tab();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= SIN_TAB[addr_a];
      data_b <= SIN_TAB[addr_b];
    end
  end

endmodule

FILE: hdl/spqv_expand.sv
module spqv_expand (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spqv_pkg::coord_t     dest_x,
  input  spqv_pkg::coord_t     dest_y,
  input  spqv_pkg::coord_t     dest_w,
  input  spqv_pkg::coord_t     dest_h,
  input  spqv_pkg::coord_t     pivot_x,
  input  spqv_pkg::coord_t     pivot_y,
  input  spqv_pkg::angle_in_t  rotation_angle,
  input  spqv_pkg::coord_t     src_u,
  input  spqv_pkg::coord_t     src_v,
  input  spqv_pkg::coord_t     src_w,
  input  spqv_pkg::coord_t     src_h,
  input  spqv_pkg::mirror_t    mirror_mode,
  output logic                 spr_valid,
  input  logic                 spr_ready,
  output spqv_pkg::sprite_t    spr,
  output spqv_pkg::corner_t    corner
);

  logic                busy;
  spqv_pkg::corner_t   cnt;
  spqv_pkg::item_t     item;
  spqv_pkg::sin_mag_t  rom_sin;
  spqv_pkg::sin_mag_t  rom_cos;
  spqv_pkg::angle_t    ang_sin;
  spqv_pkg::angle_t    ang_cos;
  logic                take;
  logic                adv;

  assign ang_sin = spqv_pkg::angle_t'(rotation_angle);
  assign ang_cos = ang_sin + spqv_pkg::angle_t'(spqv_pkg::QTR);

  assign adv      = busy && spr_ready;
  assign in_stall = busy && !(adv && cnt == spqv_pkg::CORNER_LAST);
  assign take     = in_valid && !in_stall;

  spqv_sine_rom u_rom (
    .clk    (clk),
    .en     (take),
    .addr_a (spqv_pkg::quarter_addr(ang_sin)),
    .addr_b (spqv_pkg::quarter_addr(ang_cos)),
    .data_a (rom_sin),
    .data_b (rom_cos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (adv && cnt == spqv_pkg::CORNER_LAST) begin
      busy <= 1'b0;
    end else if (adv) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.dest_x  <= dest_x;
      item.dest_y  <= dest_y;
      item.dest_w  <= dest_w;
      item.dest_h  <= dest_h;
      item.pivot_x <= pivot_x;
      item.pivot_y <= pivot_y;
      item.src_u   <= src_u;
      item.src_v   <= src_v;
      item.src_w   <= src_w;
      item.src_h   <= src_h;
      item.mirror  <= mirror_mode;
      item.sin_neg <= ang_sin[spqv_pkg::ANGLE_BITS-1];
      item.cos_neg <= ang_cos[spqv_pkg::ANGLE_BITS-1];
    end
  end

  assign spr_valid = busy;
  assign corner    = cnt;
  assign spr       = '{item: item, sin_mag: rom_sin, cos_mag: rom_cos};

endmodule

FILE: hdl/spqv_corner_pipe.sv
module spqv_corner_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                spr_valid,
  output logic                spr_ready,
  input  spqv_pkg::sprite_t   spr,
  input  spqv_pkg::corner_t   corner,
  output logic                out_valid,
  input  logic                out_stall,
  output spqv_pkg::coord_t    vertex_x,
  output spqv_pkg::coord_t    vertex_y,
  output spqv_pkg::coord_t    tex_u,
  output spqv_pkg::coord_t    tex_v,
  output spqv_pkg::corner_t   corner_index,
  output logic                last_corner
);

  typedef struct packed {
    spqv_pkg::coord_t  dx;
    spqv_pkg::coord_t  dy;
    spqv_pkg::coord_t  tu;
    spqv_pkg::coord_t  tv;
    spqv_pkg::corner_t corner;
  } carry_t;

  typedef logic signed [spqv_pkg::OFF_W-1:0]  off_t;
  typedef logic signed [spqv_pkg::TRIG_W-1:0] trig_t;
  typedef logic signed [spqv_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [spqv_pkg::ROT_W-1:0]  rot_t;
  typedef logic signed [spqv_pkg::RSUM_W-1:0] rsum_t;
  typedef logic signed [spqv_pkg::RND_W-1:0]  rnd_t;
  typedef logic signed [spqv_pkg::VSUM_W-1:0] vsum_t;
  typedef logic signed [spqv_pkg::FW:0]       tsum_t;

  localparam off_t  OFF_ONE   = off_t'(spqv_pkg::ONE_Q16);
  localparam prod_t PROD_HALF = prod_t'(spqv_pkg::HALF_Q16);
  localparam rsum_t RSUM_HALF = rsum_t'(spqv_pkg::HALF_Q16);

  // stage valids and advance enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;

  // stage 1: corner offsets, signed sine/cosine, texture
  off_t   s1_offx, s1_offy;
  spqv_pkg::coord_t s1_dw, s1_dh;
  trig_t  s1_sn, s1_cs;
  carry_t s1_c;
  // stage 2: offset times size
  prod_t  s2_px, s2_py;
  trig_t  s2_sn, s2_cs;
  carry_t s2_c;
  // stage 3: rounded, saturated corner vector
  spqv_pkg::coord_t s3_cx, s3_cy;
  trig_t  s3_sn, s3_cs;
  carry_t s3_c;
  // stage 4: rotation products
  rot_t   s4_cxc, s4_cys, s4_cxs, s4_cyc;
  carry_t s4_c;
  // stage 5: rounded rotated vector
  rnd_t   s5_rx, s5_ry;
  carry_t s5_c;

  // combinational inputs of stage 1, stage 3, stage 5 and the output stage
  logic   kx, ky, tx, ty;
  off_t   offx_next, offy_next;
  trig_t  sn_next, cs_next;
  tsum_t  tu_sum, tv_sum;
  prod_t  px_rnd, py_rnd;
  rsum_t  rx_sum, ry_sum;
  vsum_t  vx_sum, vy_sum;

  assign en6 = !out_valid || !out_stall;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign spr_ready = en1;

  always_comb begin
    kx = spqv_pkg::KX_FLAGS[corner];
    ky = spqv_pkg::KY_FLAGS[corner];
    tx = kx ^ spr.item.mirror[spqv_pkg::MIR_H];
    ty = ky ^ spr.item.mirror[spqv_pkg::MIR_V];
    offx_next = (kx ? OFF_ONE : off_t'(0)) - off_t'(spr.item.pivot_x);
    offy_next = (ky ? OFF_ONE : off_t'(0)) - off_t'(spr.item.pivot_y);
    sn_next = signed'(spqv_pkg::TRIG_W'(spr.sin_mag));
    cs_next = signed'(spqv_pkg::TRIG_W'(spr.cos_mag));
    if (spr.item.sin_neg) begin
      sn_next = -sn_next;
    end
    if (spr.item.cos_neg) begin
      cs_next = -cs_next;
    end
    tu_sum = tsum_t'(spr.item.src_u) + (tx ? tsum_t'(spr.item.src_w) : tsum_t'(0));
    tv_sum = tsum_t'(spr.item.src_v) + (ty ? tsum_t'(spr.item.src_h) : tsum_t'(0));
  end

  assign px_rnd = s2_px + PROD_HALF;
  assign py_rnd = s2_py + PROD_HALF;

  // round half up from Q32 to Q16 before adding the anchor
  assign rx_sum = rsum_t'(s4_cxc) - rsum_t'(s4_cys) + RSUM_HALF;
  assign ry_sum = rsum_t'(s4_cxs) + rsum_t'(s4_cyc) + RSUM_HALF;
  assign vx_sum = vsum_t'(s5_rx) + vsum_t'(s5_c.dx);
  assign vy_sum = vsum_t'(s5_ry) + vsum_t'(s5_c.dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= spr_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_offx     <= offx_next;
      s1_offy     <= offy_next;
      s1_dw       <= spr.item.dest_w;
      s1_dh       <= spr.item.dest_h;
      s1_sn       <= sn_next;
      s1_cs       <= cs_next;
      s1_c.dx     <= spr.item.dest_x;
      s1_c.dy     <= spr.item.dest_y;
      s1_c.tu     <= spqv_pkg::sat_coord(spqv_pkg::SAT_IN_W'(tu_sum));
      s1_c.tv     <= spqv_pkg::sat_coord(spqv_pkg::SAT_IN_W'(tv_sum));
      s1_c.corner <= corner;
    end
    if (en2) begin
      s2_px <= prod_t'(s1_offx) * prod_t'(s1_dw);
      s2_py <= prod_t'(s1_offy) * prod_t'(s1_dh);
      s2_sn <= s1_sn;
      s2_cs <= s1_cs;
      s2_c  <= s1_c;
    end
    if (en3) begin
      s3_cx <= spqv_pkg::sat_coord(signed'(px_rnd[spqv_pkg::PROD_W-1:spqv_pkg::FRAC_W]));
      s3_cy <= spqv_pkg::sat_coord(signed'(py_rnd[spqv_pkg::PROD_W-1:spqv_pkg::FRAC_W]));
      s3_sn <= s2_sn;
      s3_cs <= s2_cs;
      s3_c  <= s2_c;
    end
    if (en4) begin
      s4_cxc <= rot_t'(s3_cs) * rot_t'(s3_cx);
      s4_cys <= rot_t'(s3_sn) * rot_t'(s3_cy);
      s4_cxs <= rot_t'(s3_sn) * rot_t'(s3_cx);
      s4_cyc <= rot_t'(s3_cs) * rot_t'(s3_cy);
      s4_c   <= s3_c;
    end
    if (en5) begin
      s5_rx <= signed'(rx_sum[spqv_pkg::RSUM_W-1:spqv_pkg::FRAC_W]);
      s5_ry <= signed'(ry_sum[spqv_pkg::RSUM_W-1:spqv_pkg::FRAC_W]);
      s5_c  <= s4_c;
    end
    if (en6) begin
      vertex_x     <= spqv_pkg::sat_coord(spqv_pkg::SAT_IN_W'(vx_sum));
      vertex_y     <= spqv_pkg::sat_coord(spqv_pkg::SAT_IN_W'(vy_sum));
      tex_u        <= s5_c.tu;
      tex_v        <= s5_c.tv;
      corner_index <= s5_c.corner;
      last_corner  <= (s5_c.corner == spqv_pkg::CORNER_LAST);
    end
  end

endmodule

FILE: hdl/sprite_quad_vertex_setup.sv
// Sprite quad vertex setup. Each accepted sprite word produces four vertex words, in the
// order top-right, bottom-right, bottom-left, top-left, with last_corner set on the fourth.
// When the output is not stalled, the single output channel moves one vertex word per
// cycle, and the corner sequencer holds the sprite until its fourth corner enters the
// pipeline, so the next sprite is accepted on that same cycle. After a sprite is accepted,
// its first vertex passes the sine/cosine table read, then six register stages: offsets,
// size multiply, round and saturate, rotation multiply, round, anchor add and saturate.
// Sine and cosine come from a quarter-wave table of 2^(ANGLE_BITS-2)+1 entries read on
// two ports. All coordinates are signed Q16.16 and saturate. No clearing pass after reset.
module sprite_quad_vertex_setup (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spqv_pkg::coord_t     dest_x,
  input  spqv_pkg::coord_t     dest_y,
  input  spqv_pkg::coord_t     dest_w,
  input  spqv_pkg::coord_t     dest_h,
  input  spqv_pkg::coord_t     pivot_x,
  input  spqv_pkg::coord_t     pivot_y,
  input  spqv_pkg::angle_in_t  rotation_angle,
  input  spqv_pkg::coord_t     src_u,
  input  spqv_pkg::coord_t     src_v,
  input  spqv_pkg::coord_t     src_w,
  input  spqv_pkg::coord_t     src_h,
  input  spqv_pkg::mirror_t    mirror_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spqv_pkg::coord_t     vertex_x,
  output spqv_pkg::coord_t     vertex_y,
  output spqv_pkg::coord_t     tex_u,
  output spqv_pkg::coord_t     tex_v,
  output spqv_pkg::corner_t    corner_index,
  output logic                 last_corner
);

  logic               spr_valid;
  logic               spr_ready;
  spqv_pkg::sprite_t  spr;
  spqv_pkg::corner_t  corner;

  spqv_expand u_expand (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .dest_x         (dest_x),
    .dest_y         (dest_y),
    .dest_w         (dest_w),
    .dest_h         (dest_h),
    .pivot_x        (pivot_x),
    .pivot_y        (pivot_y),
    .rotation_angle (rotation_angle),
    .src_u          (src_u),
    .src_v          (src_v),
    .src_w          (src_w),
    .src_h          (src_h),
    .mirror_mode    (mirror_mode),
    .spr_valid      (spr_valid),
    .spr_ready      (spr_ready),
    .spr            (spr),
    .corner         (corner)
  );

  spqv_corner_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .spr_valid    (spr_valid),
    .spr_ready    (spr_ready),
    .spr          (spr),
    .corner       (corner),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .corner_index (corner_index),
    .last_corner  (last_corner)
  );

endmodule

FILE: hdl/spqv_checker.sv
module spqv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spqv_pkg::coord_t   vertex_x,
  input spqv_pkg::coord_t   vertex_y,
  input spqv_pkg::corner_t  corner_index,
  input logic               last_corner
);

  logic              in_acc;
  logic              out_acc;
  spqv_pkg::corner_t exp_corner;
  logic [4:0]        pending;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // vertex words owed to the output, and the corner expected next
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_corner <= '0;
      pending    <= '0;
    end else begin
      if (out_acc) begin
        exp_corner <= corner_index + 2'd1;
      end
      pending <= pending + (in_acc ? 5'd4 : 5'd0) - (out_acc ? 5'd1 : 5'd0);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vertex_x) && $stable(vertex_y))
    else $error("stalled vertex word changed");

  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> corner_index == exp_corner)
    else $error("vertex word out of corner order");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_corner == (corner_index == spqv_pkg::CORNER_LAST))
    else $error("last_corner does not match corner_index");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 5'd0)
    else $error("vertex word without a pending sprite");

endmodule

bind sprite_quad_vertex_setup spqv_checker u_chk (.*);
